// ----- rtl/rcs_pkg.sv -----
// Shared types, constants and the subset mask table builder for the count sketch.
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int ROW_LEN     = 8;
    localparam int MAX_OPTIONS = 70;
    localparam int OPT_W       = $clog2(MAX_OPTIONS);
    localparam int DATA_W      = 32;

    localparam logic KIND_INC   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [ROW_LEN-1:0]                  t_mask;
    typedef logic [MAX_OPTIONS-1:0][ROW_LEN-1:0] t_mask_tab;

    // Result of the shared subtractor: difference and borrow out.
    typedef struct packed {
        logic              borrow;
        logic [DATA_W-1:0] diff;
    } t_alu_res;

    // Build the k-of-8 subsets in lexicographic order of their sorted index
    // lists; entries past the subset count stay empty.
    function automatic t_mask_tab build_masks(input int k);
        t_mask_tab tab;
        int        idx [ROW_LEN];
        int        pos;
        t_mask     m;
        logic      done;
        tab  = '0;
        done = (k < 1) || (k > ROW_LEN);
        for (int i = 0; i < ROW_LEN; i++) begin
            idx[i] = i;
        end
        for (int n = 0; n < MAX_OPTIONS; n++) begin
            if (!done) begin
                m = '0;
                for (int j = 0; j < ROW_LEN; j++) begin
                    if (j < k) begin
                        m[idx[j]] = 1'b1;
                    end
                end
                tab[n] = m;
                pos = -1;
                for (int j = 0; j < ROW_LEN; j++) begin
                    if (j < k && idx[j] < ROW_LEN - k + j) begin
                        pos = j;
                    end
                end
                if (pos < 0) begin
                    done = 1'b1;
                end else begin
                    idx[pos] = idx[pos] + 1;
                    for (int j = 1; j < ROW_LEN; j++) begin
                        if (j > pos && j < k) begin
                            idx[j] = idx[j-1] + 1;
                        end
                    end
                end
            end
        end
        return tab;
    endfunction

endpackage

// ----- rtl/rcs_in_if.sv -----
// Input channel of the count sketch: operation kind and key hash.
`timescale 1ns / 1ps

interface rcs_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] key_hash;

    modport source (output valid, output kind, output key_hash, input ready);
    modport sink   (input valid, input kind, input key_hash, output ready);
endinterface

// ----- rtl/rcs_out_if.sv -----
// Output channel of the count sketch: frequency estimate.
`timescale 1ns / 1ps

interface rcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
endinterface

// ----- rtl/rcs_alu.sv -----
// Shared 32-bit subtractor used for modulo steps, increments and minimum compares.
`timescale 1ns / 1ps

module rcs_alu (
    input  logic [rcs_pkg::DATA_W-1:0] i_a,
    input  logic [rcs_pkg::DATA_W-1:0] i_b,
    output rcs_pkg::t_alu_res          o_res
);
    import rcs_pkg::*;

    logic [DATA_W:0] full;

    // Borrow out means a < b; a minus all ones is a plus one.
    assign full         = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.borrow = full[DATA_W];
    assign o_res.diff   = full[DATA_W-1:0];
endmodule

// ----- rtl/row_combination_count_sketch.sv -----
// Top level of the row combination count sketch: sequencer, counter store and shared unit.
`timescale 1ns / 1ps

// Channel  Dir  Transaction payload         Notes
// i_in     in   kind (1b), key_hash (32b)   kind 0 increments, kind 1 queries
// o_out    out  estimate (32b)              one transaction per query only
//
// After reset a clearing pass writes zero to every counter, one per cycle,
// during which i_in.ready stays low.
// A transaction is taken in idle, then runs the modulo (reciprocal multiply,
// reduce, one correcting subtract; skipped when NUM_OPTIONS is 1), then steps
// through all eight counters of the row, reading each and, for the
// COUNTERS_PER_KEY counters in the key's subset, evaluating it; a query then
// hands its estimate to the output. The counter store's one read port and
// the shared subtractor serve one counter at a time. A finished estimate
// waits in the output register while the next transaction is taken; a
// stalled output only holds the next query.
module row_combination_count_sketch #(
    parameter int NUM_ARRAYS       = 1024,
    parameter int COUNTERS_PER_KEY = 3,
    parameter int NUM_OPTIONS      = 56
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcs_in_if.sink     i_in,
    rcs_out_if.source  o_out
);
    import rcs_pkg::*;

    localparam int DEPTH     = NUM_ARRAYS * ROW_LEN;
    localparam int AW        = $clog2(DEPTH);
    localparam int RB        = $clog2(NUM_ARRAYS);
    localparam int CNT_W     = $clog2(ROW_LEN);

    localparam logic [DATA_W-1:0] ROW_MASK  = DATA_W'(NUM_ARRAYS - 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(ROW_LEN - 1);
    localparam logic [OPT_W:0]    DIVISOR   =
        (OPT_W + 1)'(NUM_OPTIONS > 1 ? NUM_OPTIONS - 1 : 1);
    // floor((2^32 - 1) / divisor): the quotient estimate is at most one short.
    localparam logic [DATA_W-1:0] RECIP     = {DATA_W{1'b1}} / DATA_W'(DIVISOR);
    localparam t_mask_tab         MASK_TAB  = build_masks(COUNTERS_PER_KEY);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RED,
        S_DIV,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_addr;     // clearing pass address
    logic                r_kind;
    logic [DATA_W-1:0]   r_div;      // hash with the row bits shifted out
    logic [DATA_W-1:0]   r_quo;      // quotient estimate
    logic [AW-1:0]       r_base;     // row times eight
    logic [OPT_W:0]      r_rem;      // reduced hash, then option index
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_min;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_estimate;

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [DATA_W-1:0]   r_rdata;

    logic [2*DATA_W-1:0] prod;
    logic [OPT_W:0]      quo_lo;
    logic [DATA_W-1:0]   alu_a;
    logic [DATA_W-1:0]   alu_b;
    t_alu_res            alu_res;
    t_mask               mask;
    logic [AW-1:0]       ctr_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                last_cnt;
    t_state              finish_state;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.estimate = r_estimate;

    // Reciprocal product; only the low bits of quotient times divisor matter
    // because the remainder estimate stays below twice the divisor.
    assign prod         = (2*DATA_W)'(r_div) * (2*DATA_W)'(RECIP);
    assign quo_lo       = r_quo[OPT_W:0] * DIVISOR;
    assign mask         = MASK_TAB[r_rem[OPT_W-1:0]];
    assign ctr_addr     = r_base | AW'(r_cnt);
    assign last_cnt     = (r_cnt == CNT_LAST);
    assign finish_state = (r_kind == KIND_QUERY) ? S_DONE : S_IDLE;

    // Operand selection for the shared subtractor.
    always_comb begin
        alu_a = r_rdata;
        alu_b = r_min;
        unique case (r_state)
            S_RED: begin
                alu_a = DATA_W'(r_div[OPT_W:0]);
                alu_b = DATA_W'(quo_lo);
            end
            S_DIV: begin
                alu_a = DATA_W'(r_rem);
                alu_b = DATA_W'(DIVISOR);
            end
            S_EVAL: begin
                if (r_kind == KIND_INC) begin
                    alu_b = '1;
                end
            end
            default: begin
            end
        endcase
    end

    rcs_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Write port: zero during the clearing pass, the incremented counter while an increment evaluates it.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ctr_addr;
        mem_wdata = alu_res.diff;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = '0;
        end else if (r_state == S_EVAL && r_kind == KIND_INC) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[ctr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the estimate once taken; a finishing query reloads it below.
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_div   <= i_in.key_hash >> RB;
                        r_base  <= AW'({i_in.key_hash & ROW_MASK, 3'b000});
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_min   <= '1;
                        r_state <= (NUM_OPTIONS > 1) ? S_MUL : S_READ;
                    end
                end
                S_MUL: begin
                    r_quo   <= prod[2*DATA_W-1:DATA_W];
                    r_state <= S_RED;
                end
                S_RED: begin
                    // Remainder estimate, below twice the divisor.
                    r_rem   <= alu_res.diff[OPT_W:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // One correcting subtract brings it below the divisor.
                    if (!alu_res.borrow) begin
                        r_rem <= alu_res.diff[OPT_W:0];
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    // Skip counters outside the key's subset.
                    if (mask[r_cnt]) begin
                        r_state <= S_EVAL;
                    end else if (last_cnt) begin
                        r_state <= finish_state;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EVAL: begin
                    if (r_kind == KIND_QUERY && alu_res.borrow) begin
                        r_min <= r_rdata;
                    end
                    if (last_cnt) begin
                        r_state <= finish_state;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_estimate  <= r_min;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- verif/row_combination_count_sketch_tb.sv -----
// Self-checking testbench for the row combination count sketch: shadow store, bursts and stalls.
`timescale 1ns / 1ps

module row_combination_count_sketch_tb;
    import rcs_pkg::*;

    // Block configuration under test: the default sizing of the sketch.
    localparam int NUM_ARRAYS       = 1024;
    localparam int COUNTERS_PER_KEY = 3;
    localparam int NUM_OPTIONS      = 56;
    localparam int ROW_SHIFT        = $clog2(NUM_ARRAYS);
    localparam int ROW_MASK         = NUM_ARRAYS - 1;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1200;
    // The clearing pass runs with no transaction; it, the long output hold-off
    // and the slowest transaction all sit far below this limit.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int LONG_HOLD      = 800;
    localparam int HOLD_AFTER     = 50;
    localparam int TAIL_CYCLES    = 200;
    localparam int HOT_KEYS       = 12;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE} t_rx_mode;

    // Shadow of the counter store and the subset table; predicts each estimate.
    class sketch_shadow;
        bit [31:0] counts [NUM_ARRAYS*ROW_LEN];
        t_mask     key_masks [NUM_OPTIONS];
        int        row_shift;
        bit [31:0] pending_estimates [$];
        int        errors;

        function new();
            int    pick [ROW_LEN];
            int    n;
            int    pos;
            int    span;
            t_mask m;
            foreach (counts[i]) counts[i] = '0;
            foreach (key_masks[i]) key_masks[i] = '0;
            for (int i = 0; i < COUNTERS_PER_KEY; i++) begin
                pick[i] = i;
            end
            // Step through the k-of-8 index lists in lexicographic order.
            n   = 0;
            pos = 0;
            while (n < NUM_OPTIONS && pos >= 0) begin
                m = '0;
                for (int i = 0; i < COUNTERS_PER_KEY; i++) begin
                    m[pick[i]] = 1'b1;
                end
                key_masks[n] = m;
                n++;
                pos = COUNTERS_PER_KEY - 1;
                while (pos >= 0 && pick[pos] == ROW_LEN - COUNTERS_PER_KEY + pos) begin
                    pos--;
                end
                if (pos >= 0) begin
                    pick[pos]++;
                    for (int j = pos + 1; j < COUNTERS_PER_KEY; j++) begin
                        pick[j] = pick[j-1] + 1;
                    end
                end
            end
            // Count the significant bits of the row mask.
            span      = NUM_ARRAYS - 1;
            row_shift = 0;
            while (span != 0) begin
                row_shift++;
                span = span >> 1;
            end
            errors = 0;
        endfunction

        function void note_transaction(logic kind, logic [31:0] key_hash);
            int        base;
            int        option;
            t_mask     m;
            bit [31:0] lowest;
            base   = int'(key_hash & 32'(NUM_ARRAYS - 1)) * ROW_LEN;
            option = 0;
            if (NUM_OPTIONS > 1) begin
                option = int'((key_hash >> row_shift) % 32'(NUM_OPTIONS - 1));
            end
            m      = key_masks[option];
            lowest = '1;
            for (int c = 0; c < ROW_LEN; c++) begin
                if (m[c]) begin
                    if (kind == KIND_INC) begin
                        counts[base+c] = counts[base+c] + 32'd1;
                    end else if (counts[base+c] < lowest) begin
                        lowest = counts[base+c];
                    end
                end
            end
            if (kind == KIND_QUERY) begin
                pending_estimates.push_back(lowest);
            end
        endfunction

        function void check_estimate(logic [31:0] estimate);
            bit [31:0] want;
            if (pending_estimates.size() == 0) begin
                errors++;
                $display("%0t: unexpected estimate, expected none, actual %h", $time, estimate);
            end else begin
                want = pending_estimates.pop_front();
                if (estimate !== want) begin
                    errors++;
                    $display("%0t: estimate mismatch, expected %h, actual %h",
                             $time, want, estimate);
                end
            end
        endfunction

        function int outstanding();
            return pending_estimates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rcs_in_if  in_ch ();
    rcs_out_if out_ch ();

    sketch_shadow shadow;
    logic [31:0]  hot_keys [HOT_KEYS];
    int           idle_cycles = 0;

    row_combination_count_sketch #(
        .NUM_ARRAYS       (NUM_ARRAYS),
        .COUNTERS_PER_KEY (COUNTERS_PER_KEY),
        .NUM_OPTIONS      (NUM_OPTIONS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Offer one transaction and hold it until the block takes it. Called and
    // returning at a rising edge, so the next offer may follow without a gap.
    task automatic offer_item(input logic kind, input logic [31:0] key_hash);
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.key_hash <= key_hash;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        shadow.note_transaction(kind, key_hash);
    endtask

    task automatic pause_sender(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the sender until every outstanding query has been answered.
    task automatic drain_estimates();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (shadow.outstanding() != 0);
    endtask

    // Mostly hit a few hot keys and a handful of rows so counters climb and
    // subsets overlap; the rest spans the whole hash range.
    function automatic logic [31:0] pick_hash();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        end else if (sel < 8) begin
            return ($urandom & ~32'(ROW_MASK)) | 32'($urandom_range(0, 3));
        end
        return $urandom;
    endfunction

    // Sender: reset, directed transactions, then random bursts.
    initial begin
        int          sent;
        int          burst;
        logic        kind;
        bit          drained_mid;
        shadow = new();
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= KIND_INC;
        in_ch.key_hash <= '0;
        for (int i = 0; i < HOT_KEYS; i++) begin
            hot_keys[i] = ($urandom & ~32'(ROW_MASK)) | 32'($urandom_range(0, 3));
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fresh row queried before any increment, then counted up twice.
        offer_item(KIND_QUERY, 32'h0000_0000);
        offer_item(KIND_INC,   32'h0000_0000);
        offer_item(KIND_INC,   32'h0000_0000);
        offer_item(KIND_QUERY, 32'h0000_0000);
        // All ones: top row and the largest shifted hash.
        offer_item(KIND_QUERY, 32'hFFFF_FFFF);
        offer_item(KIND_INC,   32'hFFFF_FFFF);
        offer_item(KIND_QUERY, 32'hFFFF_FFFF);
        // Highest reachable option, then the hash that wraps round to option zero.
        offer_item(KIND_INC,   32'((NUM_OPTIONS - 2) << ROW_SHIFT) | 32'd5);
        offer_item(KIND_QUERY, 32'((NUM_OPTIONS - 2) << ROW_SHIFT) | 32'd5);
        offer_item(KIND_QUERY, 32'((NUM_OPTIONS - 1) << ROW_SHIFT) | 32'd5);
        offer_item(KIND_INC,   32'((NUM_OPTIONS - 1) << ROW_SHIFT) | 32'd5);
        offer_item(KIND_QUERY, 32'd5);
        // Subset that shares two counters with option zero.
        offer_item(KIND_QUERY, 32'(1 << ROW_SHIFT) | 32'd5);
        // Alternating bit patterns.
        offer_item(KIND_INC,   32'hAAAA_AAAA);
        offer_item(KIND_QUERY, 32'hAAAA_AAAA);
        offer_item(KIND_INC,   32'h5555_5555);
        offer_item(KIND_QUERY, 32'h5555_5555);
        // Top row with the upper hash bits clear, and row zero through option one.
        offer_item(KIND_INC,   32'(ROW_MASK));
        offer_item(KIND_QUERY, 32'(ROW_MASK));
        offer_item(KIND_QUERY, 32'(1 << ROW_SHIFT));
        drain_estimates();

        sent        = 0;
        drained_mid = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                kind = ($urandom_range(0, 99) < 45) ? KIND_QUERY : KIND_INC;
                offer_item(kind, pick_hash());
                sent++;
            end
            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                drain_estimates();
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 12));
            end
        end

        drain_estimates();
        // Let any stray transaction surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: check each estimate, stall on a shifting pattern, and once
    // hold off long enough for the block to back up into its input.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       taken;
        bit       hold_done;
        out_ch.ready <= 1'b0;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        taken     = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                shadow.check_estimate(out_ch.estimate);
                taken++;
            end
            if (!hold_done && taken == HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE: begin
                        out_ch.ready <= 1'b1;
                    end
                    RX_HALF: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // Watchdog: give up when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
